// ===== design/tcd_pkg.sv =====
package tcd_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLS    = 64;
    localparam int FRAC_BITS   = 16;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ADDR_W      = ROW_W + COL_W;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

    localparam int ROWCNT_W = 9;
    localparam int COLCNT_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;
    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 35;

    // Magnitudes of a difference and of a sum of two Q16.16 words.
    localparam int MAG_W = VALUE_W + 1;
    // Since |a-b| <= |a|+|b|, the quotient is at most 2^FRAC_BITS.
    localparam int QUOT_W = FRAC_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    typedef struct packed {
        logic              mem_we;
        logic [ADDR_W-1:0] waddr;
        logic              mem_re;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
        logic              clear;
        logic              prep;
        logic              accumulate;
        logic              load_out;
    } tcd_cmd_t;

    typedef struct packed {
        logic den_zero;
        logic div_done;
    } tcd_status_t;

endpackage

// ===== design/tcd_divider.sv =====
module tcd_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tcd_pkg::MAG_W-1:0]   num,
    input  logic [tcd_pkg::MAG_W-1:0]   den,
    output logic                        done,
    output logic [tcd_pkg::QUOT_W-1:0]  quotient
);
    import tcd_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_W - 1);

    logic [MAG_W:0]      rem_reg, rem_next;
    logic [MAG_W-1:0]    den_reg, den_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic                fits;
    logic [MAG_W:0]      rem_sub;

    // Restoring division, one quotient bit per cycle. The first step yields
    // the integer bit; the remainder stays below twice the divisor.
    always_comb begin
        fits      = (rem_reg >= {1'b0, den_reg});
        rem_sub   = fits ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = {1'b0, num};
            den_next  = den;
            quot_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = {rem_sub[MAG_W-1:0], 1'b0};
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== design/tcd_datapath.sv =====
module tcd_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcd_pkg::tcd_cmd_t             cmd,
    input  logic [tcd_pkg::VALUE_W-1:0]   value,
    output tcd_pkg::tcd_status_t          status,
    output logic [tcd_pkg::TOTAL_W-1:0]   total,
    output logic                          zero_pair_seen
);
    import tcd_pkg::*;

    logic [VALUE_W-1:0] mem [STORE_DEPTH];
    logic [VALUE_W-1:0] a_reg, b_reg;

    logic [TOTAL_W-1:0] acc_reg, acc_next;
    logic               flag_reg, flag_next;
    logic [TOTAL_W-1:0] total_reg;
    logic               zps_reg;

    logic [MAG_W-1:0]   mag_a, mag_b, num, den;
    logic [MAG_W-1:0]   diff;
    logic               div_done;
    logic [QUOT_W-1:0]  quotient;
    logic [TOTAL_W:0]   sum;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[cmd.waddr] <= value;
        end
        if (cmd.mem_re)
        begin
            a_reg <= mem[cmd.raddr_a];
            b_reg <= mem[cmd.raddr_b];
        end
    end

    always_comb begin
        mag_a = a_reg[VALUE_W-1] ? (MAG_W'(0) - {a_reg[VALUE_W-1], a_reg})
                                 : {1'b0, a_reg};
        mag_b = b_reg[VALUE_W-1] ? (MAG_W'(0) - {b_reg[VALUE_W-1], b_reg})
                                 : {1'b0, b_reg};
        diff  = {a_reg[VALUE_W-1], a_reg} - {b_reg[VALUE_W-1], b_reg};
        num   = diff[MAG_W-1] ? (MAG_W'(0) - diff) : diff;
        den   = mag_a + mag_b;
    end

    tcd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.prep && (den == '0) == 1'b0),
        .num      (num),
        .den      (den),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb begin
        sum       = {1'b0, acc_reg} + (TOTAL_W + 1)'(quotient);
        acc_next  = acc_reg;
        flag_next = flag_reg;
        if (cmd.clear)
        begin
            acc_next  = '0;
            flag_next = 1'b0;
        end
        else
        begin
            if (cmd.prep && den == '0)
            begin
                flag_next = 1'b1;
            end
            if (cmd.accumulate)
            begin
                acc_next = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            flag_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            total_reg <= acc_reg;
            zps_reg   <= flag_reg;
        end
    end

    assign status.den_zero = (den == '0);
    assign status.div_done = div_done;
    assign total           = total_reg;
    assign zero_pair_seen  = zps_reg;

endmodule

// ===== design/tcd_ctrl.sv =====
module tcd_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    output logic                            out_valid,
    input  logic                            out_ready,
    input  tcd_pkg::tcd_status_t            status,
    output tcd_pkg::tcd_cmd_t               cmd
);
    import tcd_pkg::*;

    typedef enum logic [2:0] {S_LOAD, S_READ, S_PREP, S_DIV, S_FINISH} state_t;

    state_t              state_reg, state_next;
    logic [ROWCNT_W-1:0] rowcnt_reg, rowcnt_next;
    logic [COLCNT_W-1:0] colcnt_reg, colcnt_next;
    logic [ROW_W-1:0]    lrow_reg, lrow_next;
    logic [COL_W-1:0]    lcol_reg, lcol_next;
    logic [COL_W-1:0]    first_reg, first_next;
    logic [COL_W-1:0]    second_reg, second_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                out_valid_reg, out_valid_next;

    logic [ROW_W-1:0]    rows_m1;
    logic [COL_W-1:0]    cols_m1;
    logic                accept, last_elem, advance;

    // A count of zero acts as one; a count above the maximum is clamped.
    always_comb begin
        if (rowcnt_reg == '0)
            rows_m1 = '0;
        else if (rowcnt_reg > ROWCNT_W'(MAX_ROWS))
            rows_m1 = ROW_W'(MAX_ROWS - 1);
        else
            rows_m1 = ROW_W'(rowcnt_reg - 1'b1);
        if (colcnt_reg == '0)
            cols_m1 = '0;
        else if (colcnt_reg > COLCNT_W'(MAX_COLS))
            cols_m1 = COL_W'(MAX_COLS - 1);
        else
            cols_m1 = COL_W'(colcnt_reg - 1'b1);
    end

    always_comb begin
        accept    = (state_reg == S_LOAD) && in_valid;
        last_elem = (lrow_reg == rows_m1) && (lcol_reg == cols_m1);
        advance   = ((state_reg == S_PREP) && status.den_zero)
                 || ((state_reg == S_DIV) && status.div_done);

        cmd            = '0;
        cmd.mem_we     = accept;
        cmd.waddr      = {lcol_reg, lrow_reg};
        cmd.mem_re     = (state_reg == S_READ);
        cmd.raddr_a    = {first_reg, row_reg};
        cmd.raddr_b    = {second_reg, row_reg};
        cmd.clear      = accept && last_elem;
        cmd.prep       = (state_reg == S_PREP);
        cmd.accumulate = (state_reg == S_DIV) && status.div_done;

        state_next     = state_reg;
        rowcnt_next    = rowcnt_reg;
        colcnt_next    = colcnt_reg;
        lrow_next      = lrow_reg;
        lcol_next      = lcol_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (lrow_reg == rows_m1)
                    begin
                        lrow_next = '0;
                        lcol_next = lcol_reg + 1'b1;
                    end
                    else
                    begin
                        lrow_next = lrow_reg + 1'b1;
                    end
                    if (last_elem)
                    begin
                        first_next  = '0;
                        second_next = COL_W'(1);
                        row_next    = '0;
                        state_next  = (cols_m1 == '0) ? S_FINISH : S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = status.den_zero ? S_READ : S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_READ;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    lrow_next      = '0;
                    lcol_next      = '0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        // Walk the rows, then the second column, then the first column.
        if (advance)
        begin
            if (row_reg == rows_m1)
            begin
                row_next = '0;
                if (second_reg == cols_m1)
                begin
                    if (first_reg == cols_m1 - 1'b1)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        first_next  = first_reg + 1'b1;
                        second_next = first_reg + COL_W'(2);
                    end
                end
                else
                begin
                    second_next = second_reg + 1'b1;
                end
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end

        // A register write restarts the load of the matrix.
        if (cfg_we)
        begin
            lrow_next = '0;
            lcol_next = '0;
            if (cfg_index == REG_ROW_COUNT)
                rowcnt_next = cfg_data[ROWCNT_W-1:0];
            else if (cfg_index == REG_COLUMN_COUNT)
                colcnt_next = cfg_data[COLCNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            rowcnt_reg    <= ROWCNT_W'(MAX_ROWS);
            colcnt_reg    <= COLCNT_W'(MAX_COLS);
            lrow_reg      <= '0;
            lcol_reg      <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rowcnt_reg    <= rowcnt_next;
            colcnt_reg    <= colcnt_next;
            lrow_reg      <= lrow_next;
            lcol_reg      <= lcol_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ || state_reg == S_PREP || state_reg == S_DIV)
        |-> first_reg < second_reg && second_reg <= cols_m1)
        else $error("pair walk columns out of order");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |-> lcol_reg <= cols_m1)
        else $error("load column beyond configured count");

    a_hold_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && !out_ready)
        |=> state_reg == S_FINISH)
        else $error("result overwrote a pending one");
`endif

endmodule

// ===== design/total_canberra_distance_core.sv =====
// Total Canberra distance over all column pairs of a loaded matrix.
// Requests on the input channel (in_valid/in_ready) carry one signed Q16.16
// element each, column-major, one per cycle while loading. The request that
// completes row_count x column_count elements starts the pair walk; in_ready
// is low until the result is loaded out. The result request (total, zero_pair_seen)
// is held in an output register under out_valid/out_ready.
// Each pair term takes one memory read, a setup state, the shared
// bit-serial divider and an accumulate when the divider is done; a term
// whose two elements are both zero skips the divider. The walk covers
// rows * cols * (cols - 1) / 2 terms.
// While a result waits, loading of the next matrix goes on; a finished walk
// then holds until the receiver takes the earlier result.
// Configuration writes (index 0 row_count, index 1 column_count) restart the
// load. Reset sets 256 rows and 64 columns and an empty load; the element
// memory is not cleared.
module total_canberra_distance_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [tcd_pkg::VALUE_W-1:0] value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tcd_pkg::TOTAL_W-1:0]     total,
    output logic                            zero_pair_seen
);
    import tcd_pkg::*;

    tcd_cmd_t    cmd;
    tcd_status_t status;

    tcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcd_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .value          (value),
        .status         (status),
        .total          (total),
        .zero_pair_seen (zero_pair_seen)
    );

endmodule
